// ===== rtl/pdct_pkg.sv =====
// Shared types and codes for the port decoder classify table.
// Used by pdct_cell, pdct_chain and port_decoder_classify_table.
`timescale 1ns / 1ps

package pdct_pkg;

    // Default table sizes.
    localparam int SMALL_DEPTH_DEF = 32;
    localparam int PORT_DEPTH_DEF  = 512;

    // Decoder ids at or above this count are refused on insert.
    localparam int DECODER_COUNT = 64;

    localparam int KEY_W = 32;
    localparam int DEC_W = 6;
    localparam int PORT_W = 16;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [DEC_W-1:0]        t_dec;

    // Request functions.
    localparam logic [1:0] F_INSERT = 2'd0;
    localparam logic [1:0] F_LOOKUP = 2'd1;
    localparam logic [1:0] F_BIND   = 2'd2;

    // Table codes.
    localparam logic [1:0] TBL_IP  = 2'd0;
    localparam logic [1:0] TBL_UDP = 2'd1;
    localparam logic [1:0] TBL_TCP = 2'd2;
    localparam logic [1:0] TBL_RPC = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;

    // Search token that walks along a chain of cells.
    typedef struct packed {
        logic valid;
        logic found;
        t_key key;
        t_dec dec;
    } t_probe;

    // Append request broadcast to every cell of a chain.
    typedef struct packed {
        logic en;
        t_key key;
        t_dec dec;
    } t_write;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_FALLBACK,
        S_BIND_PORT,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/pdct_cell.sv =====
// One table entry: a stored key and decoder plus one stage of the search path.
// Depends on pdct_pkg.
`timescale 1ns / 1ps

module pdct_cell
    import pdct_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_probe           i_probe,
    input  logic [CNT_W-1:0] i_count,
    input  t_write           i_write,
    output t_probe           o_probe
);

    t_key   r_key;
    t_dec   r_dec;
    t_probe r_probe;
    t_probe n_probe;
    logic   live;

    // The entry holds data only once the fill count has passed it.
    assign live = CNT_W'(INDEX) < i_count;

    // Compare the passing token with this entry and mark a match.
    always_comb begin
        n_probe = i_probe;
        if (i_probe.valid && !i_probe.found && live && (r_key == i_probe.key)) begin
            n_probe.found = 1'b1;
            n_probe.dec   = r_dec;
        end
    end

    // Hand the token to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    // Take a new entry when this cell is the next free place.
    always_ff @(posedge i_clk) begin
        if (i_write.en && (i_count == CNT_W'(INDEX))) begin
            r_key <= i_write.key;
            r_dec <= i_write.dec;
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== rtl/pdct_chain.sv =====
// One keyed table: a row of pdct_cell entries with its fill count.
// Depends on pdct_pkg and pdct_cell.
`timescale 1ns / 1ps

module pdct_chain
    import pdct_pkg::*;
#(
    parameter int DEPTH = SMALL_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_probe i_start,
    input  t_write i_write,
    output t_probe o_result,
    output logic   o_full
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    t_probe           link [DEPTH+1];

    assign o_full = (r_count == CNT_W'(DEPTH));

    // Fill count; entries are appended at the count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_write.en && !o_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign link[0] = i_start;

    // The row of cells; the search token moves one cell per cycle.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        pdct_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (link[k]),
            .i_count (r_count),
            .i_write (i_write),
            .o_probe (link[k+1])
        );
    end

    assign o_result = link[DEPTH];

endmodule

// ===== rtl/port_decoder_classify_table.sv =====
// A search walks one table cell per cycle; an insert or lookup searches the chosen table,
// a lookup may fall back to a second search of the same port table, a bind searches
// the rpc table and then the port table, and a bad request skips the search.
// Throughput: one request at a time; the next is taken the cycle after the result
// enters the output register.
// Reset empties all tables at once by clearing their fill counts.
`timescale 1ns / 1ps

module port_decoder_classify_table
    import pdct_pkg::*;
#(
    parameter int SMALL_TABLE_DEPTH = SMALL_DEPTH_DEF,
    parameter int PORT_TABLE_DEPTH  = PORT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [1:0]         i_table_select,
    input  logic signed [31:0] i_primary_key,
    input  logic [15:0]        i_second_port,
    input  logic               i_use_fallback,
    input  logic [5:0]         i_decoder_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [5:0]         o_decoder_out,
    output logic signed [31:0] o_matched_key,
    output logic               o_fallback_hit
);

    t_state r_state, n_state;

    // Captured request.
    logic [1:0]  r_func, n_func;
    logic [1:0]  r_sel, n_sel;
    t_key        r_key, n_key;
    logic [15:0] r_port, n_port;
    logic        r_fb, n_fb;
    t_dec        r_dec, n_dec;
    logic [1:0]  r_tbl, n_tbl;

    // Pending result.
    logic [2:0] r_res_status, n_res_status;
    t_dec       r_res_dec, n_res_dec;
    t_key       r_res_key, n_res_key;
    logic       r_res_fhit, n_res_fhit;

    // Output register.
    logic       r_out_valid, n_out_valid;
    logic [2:0] r_out_status, n_out_status;
    t_dec       r_out_dec, n_out_dec;
    t_key       r_out_key, n_out_key;
    logic       r_out_fhit, n_out_fhit;

    // Search launch and table append controls.
    logic       start_en;
    logic [1:0] start_tbl;
    t_key       start_key;
    logic [1:0] wr_tbl;
    t_write     wr;

    t_probe start [4];
    t_write write [4];
    t_probe ret_all [4];
    logic   full [4];
    t_probe ret;
    t_key   neg_port;
    t_key   ext_port;
    logic   port_tbl;

    assign neg_port = $signed(32'd0 - {16'd0, r_port});
    assign ext_port = $signed({16'd0, r_port});
    assign port_tbl = (r_sel == TBL_UDP) || (r_sel == TBL_TCP);
    assign ret      = ret_all[r_tbl];

    // Route the launch and append controls to the chosen table.
    always_comb begin
        for (int t = 0; t < 4; t++) begin
            start[t].valid = start_en && (start_tbl == 2'(t));
            start[t].found = 1'b0;
            start[t].key   = start_key;
            start[t].dec   = '0;
            write[t].en    = wr.en && (wr_tbl == 2'(t));
            write[t].key   = wr.key;
            write[t].dec   = wr.dec;
        end
    end

    // The four tables.
    pdct_chain #(.DEPTH(SMALL_TABLE_DEPTH)) u_ip (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_start (start[TBL_IP]), .i_write (write[TBL_IP]),
        .o_result (ret_all[TBL_IP]), .o_full (full[TBL_IP])
    );

    pdct_chain #(.DEPTH(PORT_TABLE_DEPTH)) u_udp (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_start (start[TBL_UDP]), .i_write (write[TBL_UDP]),
        .o_result (ret_all[TBL_UDP]), .o_full (full[TBL_UDP])
    );

    pdct_chain #(.DEPTH(PORT_TABLE_DEPTH)) u_tcp (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_start (start[TBL_TCP]), .i_write (write[TBL_TCP]),
        .o_result (ret_all[TBL_TCP]), .o_full (full[TBL_TCP])
    );

    pdct_chain #(.DEPTH(SMALL_TABLE_DEPTH)) u_rpc (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_start (start[TBL_RPC]), .i_write (write[TBL_RPC]),
        .o_result (ret_all[TBL_RPC]), .o_full (full[TBL_RPC])
    );

    // Request sequencer: next state, launches, appends and results.
    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_sel        = r_sel;
        n_key        = r_key;
        n_port       = r_port;
        n_fb         = r_fb;
        n_dec        = r_dec;
        n_tbl        = r_tbl;
        n_res_status = r_res_status;
        n_res_dec    = r_res_dec;
        n_res_key    = r_res_key;
        n_res_fhit   = r_res_fhit;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_dec    = r_out_dec;
        n_out_key    = r_out_key;
        n_out_fhit   = r_out_fhit;
        start_en     = 1'b0;
        start_tbl    = TBL_IP;
        start_key    = i_primary_key;
        wr_tbl       = r_sel;
        wr.en        = 1'b0;
        wr.key       = r_key;
        wr.dec       = r_dec;
        o_stall      = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func       = i_func;
                    n_sel        = i_table_select;
                    n_key        = i_primary_key;
                    n_port       = i_second_port;
                    n_fb         = i_use_fallback;
                    n_dec        = i_decoder_in;
                    n_res_status = ST_BAD;
                    n_res_dec    = '0;
                    n_res_key    = '0;
                    n_res_fhit   = 1'b0;
                    n_state      = S_EMIT;
                    unique case (i_func)
                        F_INSERT: begin
                            if (int'(i_decoder_in) < DECODER_COUNT) begin
                                start_en  = 1'b1;
                                start_tbl = i_table_select;
                                n_tbl     = i_table_select;
                                n_state   = S_FIRST;
                            end
                        end
                        F_LOOKUP: begin
                            start_en  = 1'b1;
                            start_tbl = i_table_select;
                            n_tbl     = i_table_select;
                            n_state   = S_FIRST;
                        end
                        F_BIND: begin
                            if ((i_table_select == TBL_UDP) || (i_table_select == TBL_TCP)) begin
                                start_en  = 1'b1;
                                start_tbl = TBL_RPC;
                                n_tbl     = TBL_RPC;
                                n_state   = S_FIRST;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_FIRST: begin
                if (ret.valid) begin
                    n_state = S_EMIT;
                    unique case (r_func)
                        F_INSERT: begin
                            if (ret.found) begin
                                n_res_status = ST_PRESENT;
                            end else if (full[r_sel]) begin
                                n_res_status = ST_FULL;
                            end else begin
                                wr.en        = 1'b1;
                                n_res_status = ST_OK;
                                n_res_key    = r_key;
                            end
                        end
                        F_LOOKUP: begin
                            if (ret.found) begin
                                n_res_status = ST_OK;
                                n_res_dec    = ret.dec;
                                n_res_key    = r_key;
                            end else if (r_fb && port_tbl) begin
                                start_en  = 1'b1;
                                start_tbl = r_sel;
                                start_key = neg_port;
                                n_tbl     = r_sel;
                                n_state   = S_FALLBACK;
                            end else begin
                                n_res_status = ST_MISS;
                            end
                        end
                        F_BIND: begin
                            if (ret.found) begin
                                n_dec     = ret.dec;
                                start_en  = 1'b1;
                                start_tbl = r_sel;
                                start_key = ext_port;
                                n_tbl     = r_sel;
                                n_state   = S_BIND_PORT;
                            end else begin
                                n_res_status = ST_MISS;
                            end
                        end
                        default: begin
                            n_res_status = ST_BAD;
                        end
                    endcase
                end
            end

            S_FALLBACK: begin
                if (ret.valid) begin
                    n_state = S_EMIT;
                    if (ret.found) begin
                        n_res_status = ST_OK;
                        n_res_dec    = ret.dec;
                        n_res_key    = neg_port;
                        n_res_fhit   = 1'b1;
                    end else begin
                        n_res_status = ST_MISS;
                    end
                end
            end

            S_BIND_PORT: begin
                if (ret.valid) begin
                    n_state = S_EMIT;
                    if (ret.found) begin
                        n_res_status = ST_PRESENT;
                    end else if (full[r_sel]) begin
                        n_res_status = ST_FULL;
                    end else begin
                        wr.en        = 1'b1;
                        wr.key       = ext_port;
                        n_res_status = ST_OK;
                        n_res_dec    = r_dec;
                        n_res_key    = ext_port;
                    end
                end
            end

            S_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_dec    = r_res_dec;
                    n_out_key    = r_res_key;
                    n_out_fhit   = r_res_fhit;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Request, result and output payload.
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_sel        <= n_sel;
        r_key        <= n_key;
        r_port       <= n_port;
        r_fb         <= n_fb;
        r_dec        <= n_dec;
        r_tbl        <= n_tbl;
        r_res_status <= n_res_status;
        r_res_dec    <= n_res_dec;
        r_res_key    <= n_res_key;
        r_res_fhit   <= n_res_fhit;
        r_out_status <= n_out_status;
        r_out_dec    <= n_out_dec;
        r_out_key    <= n_out_key;
        r_out_fhit   <= n_out_fhit;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_decoder_out  = r_out_dec;
    assign o_matched_key  = r_out_key;
    assign o_fallback_hit = r_out_fhit;

endmodule

// ===== dv/tb_port_decoder_classify_table.sv =====
// Self-checking testbench for port_decoder_classify_table: directed, random and table-fill
// requests are checked against a behavioral copy of the four trigger tables.
// Depends on pdct_pkg and the port_decoder_classify_table RTL.
`timescale 1ns / 1ps

module tb_port_decoder_classify_table;
    import pdct_pkg::*;

    // The package names three functions; the fourth encoding is undefined.
    localparam logic [1:0] F_UNDEFINED = 2'd3;
    localparam int DRAIN_CYCLES = 2 * PORT_DEPTH_DEF + 64;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] table_select;
        t_key       primary_key;
        logic [15:0] second_port;
        logic       use_fallback;
        t_dec       decoder_in;
    } t_classify_request;

    typedef struct packed {
        logic [2:0] status;
        t_dec       decoder_out;
        t_key       matched_key;
        logic       fallback_hit;
    } t_classify_result;

    typedef struct packed {
        t_key key;
        t_dec dec;
    } t_trigger_entry;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic [1:0]         i_table_select;
    logic signed [31:0] i_primary_key;
    logic [15:0]        i_second_port;
    logic               i_use_fallback;
    logic [5:0]         i_decoder_in;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_status;
    logic [5:0]         o_decoder_out;
    logic signed [31:0] o_matched_key;
    logic               o_fallback_hit;

    // Behavioral copy of the tables. Order inside a table does not affect any
    // answer, so entries are simply appended.
    t_trigger_entry   table_mem[4][PORT_DEPTH_DEF];
    int               table_count[4];
    t_classify_result expected_results[$];
    t_classify_result oldest_result;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               mismatch_count = 0;
    int               requests_sent = 0;
    int               results_checked = 0;

    port_decoder_classify_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_table_select (i_table_select),
        .i_primary_key  (i_primary_key),
        .i_second_port  (i_second_port),
        .i_use_fallback (i_use_fallback),
        .i_decoder_in   (i_decoder_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_decoder_out  (o_decoder_out),
        .o_matched_key  (o_matched_key),
        .o_fallback_hit (o_fallback_hit)
    );

    always #5 i_clk = ~i_clk;

    // Table model helpers.
    function automatic int table_cap(logic [1:0] sel);
        return (sel == TBL_UDP || sel == TBL_TCP) ? PORT_DEPTH_DEF : SMALL_DEPTH_DEF;
    endfunction

    function automatic int find_key(logic [1:0] sel, t_key key);
        for (int i = 0; i < table_count[sel]; i++) begin
            if (table_mem[sel][i].key == key) return i;
        end
        return -1;
    endfunction

    function automatic logic [2:0] add_trigger(logic [1:0] sel, t_key key, t_dec dec);
        if (find_key(sel, key) >= 0) return ST_PRESENT;
        if (table_count[sel] >= table_cap(sel)) return ST_FULL;
        table_mem[sel][table_count[sel]] = '{key: key, dec: dec};
        table_count[sel]++;
        return ST_OK;
    endfunction

    // Computes the answer to one request and updates the table copy.
    function automatic t_classify_result classify_predict(t_classify_request r);
        t_classify_result res;
        int   idx;
        t_key neg_port;
        t_key bind_port;
        t_dec prog_dec;
        res = '{status: ST_BAD, decoder_out: '0, matched_key: '0, fallback_hit: 1'b0};
        neg_port = t_key'(0) - t_key'({16'd0, r.second_port});
        bind_port = t_key'({16'd0, r.second_port});
        case (r.func)
            F_INSERT: begin
                if (r.decoder_in < DECODER_COUNT) begin
                    res.status = add_trigger(r.table_select, r.primary_key, r.decoder_in);
                    if (res.status == ST_OK) res.matched_key = r.primary_key;
                end
            end
            F_LOOKUP: begin
                idx = find_key(r.table_select, r.primary_key);
                if (idx >= 0) begin
                    res.status = ST_OK;
                    res.decoder_out = table_mem[r.table_select][idx].dec;
                    res.matched_key = r.primary_key;
                end else begin
                    res.status = ST_MISS;
                    // Server-side triggers are stored under the negated port.
                    if (r.use_fallback &&
                            (r.table_select == TBL_UDP || r.table_select == TBL_TCP)) begin
                        idx = find_key(r.table_select, neg_port);
                        if (idx >= 0) begin
                            res.status = ST_OK;
                            res.decoder_out = table_mem[r.table_select][idx].dec;
                            res.matched_key = neg_port;
                            res.fallback_hit = 1'b1;
                        end
                    end
                end
            end
            F_BIND: begin
                if (r.table_select == TBL_UDP || r.table_select == TBL_TCP) begin
                    idx = find_key(TBL_RPC, r.primary_key);
                    if (idx >= 0) begin
                        prog_dec = table_mem[TBL_RPC][idx].dec;
                        res.status = add_trigger(r.table_select, bind_port, prog_dec);
                        if (res.status == ST_OK) begin
                            res.decoder_out = prog_dec;
                            res.matched_key = bind_port;
                        end
                    end else begin
                        res.status = ST_MISS;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Sends one request, holding it until the block takes it.
    task automatic issue_request(t_classify_request r);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= r.func;
        i_table_select <= r.table_select;
        i_primary_key  <= r.primary_key;
        i_second_port  <= r.second_port;
        i_use_fallback <= r.use_fallback;
        i_decoder_in   <= r.decoder_in;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(classify_predict(r));
        requests_sent++;
    endtask

    task automatic send_fields(logic [1:0] func, logic [1:0] sel, t_key key,
                               logic [15:0] port, logic fb, t_dec dec);
        issue_request('{func: func, table_select: sel, primary_key: key,
                        second_port: port, use_fallback: fb, decoder_in: dec});
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Key choice biased toward stored keys, ports, negated ports and extremes.
    function automatic t_key random_key(logic [1:0] sel);
        int unsigned pick;
        t_key key;
        pick = $urandom_range(0, 9);
        if (pick < 4 && table_count[sel] > 0)
            key = table_mem[sel][$urandom_range(0, table_count[sel] - 1)].key;
        else if (pick < 7)
            key = t_key'($urandom_range(0, 65535));
        else if (pick == 7)
            key = t_key'(0) - t_key'($urandom_range(0, 65535));
        else if (pick == 8)
            case ($urandom_range(0, 3))
                0: key = 32'sh8000_0000;
                1: key = 32'sh7fff_ffff;
                2: key = '0;
                default: key = '1;
            endcase
        else
            key = t_key'($urandom);
        return key;
    endfunction

    function automatic t_key fresh_key(logic [1:0] sel);
        t_key key;
        do key = random_key(sel); while (find_key(sel, key) >= 0);
        return key;
    endfunction

    function automatic logic [15:0] fresh_port(logic [1:0] sel);
        logic [15:0] port;
        do port = 16'($urandom_range(0, 65535));
        while (find_key(sel, t_key'({16'd0, port})) >= 0);
        return port;
    endfunction

    function automatic logic [1:0] random_table();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return TBL_IP;
        if (pick < 5) return TBL_UDP;
        if (pick < 8) return TBL_TCP;
        return TBL_RPC;
    endfunction

    function automatic logic [15:0] random_program_port(logic [1:0] sel);
        if ($urandom_range(0, 2) == 0 && table_count[sel] > 0)
            return 16'(table_mem[sel][$urandom_range(0, table_count[sel] - 1)].key);
        return 16'($urandom_range(0, 65535));
    endfunction

    // Empty-table misses, extreme keys, duplicates, fallback and bind success, duplicate, miss and bad-table outcomes.
    task automatic test_directed();
        send_fields(F_LOOKUP, TBL_IP, 32'sd6, 16'd0, 1'b0, 6'd0);
        send_fields(F_LOOKUP, TBL_UDP, 32'sd53, 16'd53, 1'b1, 6'd0);
        send_fields(F_LOOKUP, TBL_RPC, 32'sd100000, 16'd0, 1'b0, 6'd0);
        send_fields(F_INSERT, TBL_IP, 32'sh8000_0000, 16'd0, 1'b0, 6'd0);
        send_fields(F_INSERT, TBL_IP, 32'sh7fff_ffff, 16'hffff, 1'b1, 6'd63);
        send_fields(F_INSERT, TBL_IP, 32'sd6, 16'd0, 1'b0, 6'd17);
        send_fields(F_INSERT, TBL_IP, 32'sd6, 16'd0, 1'b0, 6'd18);
        send_fields(F_INSERT, TBL_IP, -32'sd1, 16'd0, 1'b0, 6'd3);
        send_fields(F_LOOKUP, TBL_IP, 32'sh8000_0000, 16'd0, 1'b0, 6'd0);
        send_fields(F_LOOKUP, TBL_IP, 32'sh7fff_ffff, 16'd1, 1'b1, 6'd0);
        // Fallback is ignored on the ip table even though -1 is stored.
        send_fields(F_LOOKUP, TBL_IP, 32'sd5, 16'd1, 1'b1, 6'd0);
        send_fields(F_INSERT, TBL_UDP, -32'sd53, 16'd0, 1'b0, 6'd7);
        send_fields(F_INSERT, TBL_UDP, 32'sd0, 16'd0, 1'b0, 6'd1);
        send_fields(F_LOOKUP, TBL_UDP, 32'sd1234, 16'd53, 1'b1, 6'd0);
        send_fields(F_LOOKUP, TBL_UDP, 32'sd1234, 16'd53, 1'b0, 6'd0);
        send_fields(F_LOOKUP, TBL_UDP, 32'sd1234, 16'd0, 1'b1, 6'd0);
        send_fields(F_LOOKUP, TBL_TCP, 32'sd1234, 16'd53, 1'b1, 6'd0);
        send_fields(F_UNDEFINED, TBL_TCP, 32'sd80, 16'd80, 1'b1, 6'd5);
        send_fields(F_INSERT, TBL_RPC, 32'sd100003, 16'd0, 1'b0, 6'd9);
        send_fields(F_BIND, TBL_TCP, 32'sd100003, 16'd2049, 1'b0, 6'd0);
        send_fields(F_BIND, TBL_TCP, 32'sd100003, 16'd2049, 1'b0, 6'd0);
        send_fields(F_BIND, TBL_UDP, 32'sd100003, 16'hffff, 1'b0, 6'd0);
        send_fields(F_BIND, TBL_IP, 32'sd100003, 16'd111, 1'b0, 6'd0);
        send_fields(F_BIND, TBL_RPC, 32'sd100003, 16'd111, 1'b0, 6'd0);
        send_fields(F_BIND, TBL_TCP, 32'sd100005, 16'd111, 1'b0, 6'd0);
        send_fields(F_LOOKUP, TBL_TCP, 32'sd2049, 16'd0, 1'b0, 6'd0);
    endtask

    // Random mix of inserts, lookups, binds and undefined requests.
    task automatic test_random_traffic(int count);
        t_classify_request r;
        int unsigned kind;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            r.second_port  = 16'($urandom_range(0, 65535));
            r.use_fallback = 1'($urandom_range(0, 1));
            r.decoder_in   = t_dec'($urandom_range(0, 63));
            if (kind < 35) begin
                r.func = F_INSERT;
                r.table_select = random_table();
                r.primary_key = random_key(r.table_select);
            end else if (kind < 75) begin
                r.func = F_LOOKUP;
                r.table_select = random_table();
                r.primary_key = random_key(r.table_select);
                // Aim the source port at a stored negated port now and then.
                if ($urandom_range(0, 1) == 1 && table_count[r.table_select] > 0)
                    r.second_port = 16'(t_key'(0) - table_mem[r.table_select]
                        [$urandom_range(0, table_count[r.table_select] - 1)].key);
            end else if (kind < 95) begin
                r.func = F_BIND;
                case ($urandom_range(0, 9))
                    0: r.table_select = TBL_IP;
                    1: r.table_select = TBL_RPC;
                    2, 3, 4, 5: r.table_select = TBL_UDP;
                    default: r.table_select = TBL_TCP;
                endcase
                r.primary_key = random_key(TBL_RPC);
                r.second_port = random_program_port(r.table_select);
            end else begin
                r.func = F_UNDEFINED;
                r.table_select = 2'($urandom_range(0, 3));
                r.primary_key = t_key'($urandom);
            end
            issue_request(r);
        end
    endtask

    // Fill the ip and rpc tables, then probe past the end.
    task automatic test_small_tables_full();
        logic [1:0] sel;
        for (int t = 0; t < 2; t++) begin
            sel = (t == 0) ? TBL_IP : TBL_RPC;
            while (table_count[sel] < SMALL_DEPTH_DEF)
                send_fields(F_INSERT, sel, fresh_key(sel), 16'($urandom), 1'b0,
                            t_dec'($urandom_range(0, 63)));
            send_fields(F_INSERT, sel, fresh_key(sel), 16'd0, 1'b0, 6'd1);
            send_fields(F_INSERT, sel, table_mem[sel][0].key, 16'd0, 1'b0, 6'd1);
            send_fields(F_LOOKUP, sel, table_mem[sel][SMALL_DEPTH_DEF - 1].key,
                        16'd0, 1'b1, 6'd0);
        end
    endtask

    // Fill the udp table by inserts and binds, then probe past the end.
    task automatic test_udp_table_full();
        logic [1:0] sel;
        t_key       prog_key;
        sel = TBL_UDP;
        while (table_count[sel] < PORT_DEPTH_DEF) begin
            prog_key = table_mem[TBL_RPC][$urandom_range(0, table_count[TBL_RPC] - 1)].key;
            if ($urandom_range(0, 3) == 0)
                send_fields(F_BIND, sel, prog_key, fresh_port(sel), 1'b0, 6'd0);
            else
                send_fields(F_INSERT, sel, fresh_key(sel), 16'($urandom), 1'b0,
                            t_dec'($urandom_range(0, 63)));
        end
        prog_key = table_mem[TBL_RPC][0].key;
        send_fields(F_INSERT, sel, fresh_key(sel), 16'd0, 1'b0, 6'd2);
        send_fields(F_BIND, sel, prog_key, fresh_port(sel), 1'b0, 6'd0);
        send_fields(F_BIND, sel, prog_key, random_program_port(sel), 1'b0, 6'd0);
        send_fields(F_INSERT, sel, table_mem[sel][PORT_DEPTH_DEF - 1].key,
                    16'd0, 1'b0, 6'd2);
        repeat (6)
            send_fields(F_LOOKUP, sel, random_key(sel),
                        16'(t_key'(0) - table_mem[sel][$urandom_range(0,
                            PORT_DEPTH_DEF - 1)].key), 1'b1, 6'd0);
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: status %0d", o_status);
                mismatch_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                results_checked++;
                if (o_status !== oldest_result.status) begin
                    $error("status: expected %0d, actual %0d", oldest_result.status, o_status);
                    mismatch_count++;
                end
                if (o_decoder_out !== oldest_result.decoder_out) begin
                    $error("decoder_out: expected %0d, actual %0d",
                           oldest_result.decoder_out, o_decoder_out);
                    mismatch_count++;
                end
                if (o_matched_key !== oldest_result.matched_key) begin
                    $error("matched_key: expected %0d, actual %0d",
                           oldest_result.matched_key, o_matched_key);
                    mismatch_count++;
                end
                if (o_fallback_hit !== oldest_result.fallback_hit) begin
                    $error("fallback_hit: expected %0d, actual %0d",
                           oldest_result.fallback_hit, o_fallback_hit);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver stall, redrawn every cycle.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial begin
        #50_000_000;
        $display("port_decoder_classify_table verification failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_func         = F_INSERT;
        i_table_select = TBL_IP;
        i_primary_key  = '0;
        i_second_port  = '0;
        i_use_fallback = 1'b0;
        i_decoder_in   = '0;
        for (int t = 0; t < 4; t++) table_count[t] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(35, 73);
        test_directed();
        test_random_traffic(90);
        set_idling(73, 35);
        test_random_traffic(90);
        set_idling(0, 0);
        test_random_traffic(80);
        test_small_tables_full();
        test_udp_table_full();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results: directed, random, table fill.",
                 requests_sent, results_checked);
        $display("Final occupancy ip %0d, udp %0d, tcp %0d, rpc %0d; %0d mismatches.",
                 table_count[TBL_IP], table_count[TBL_UDP], table_count[TBL_TCP],
                 table_count[TBL_RPC], mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("port_decoder_classify_table verification clean");
        end else begin
            $display("port_decoder_classify_table verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pdct_pkg.sv
rtl/pdct_cell.sv
rtl/pdct_chain.sv
rtl/port_decoder_classify_table.sv
dv/tb_port_decoder_classify_table.sv
